// ----- hdl/swkd_pkg.sv -----
// ----------------------------------------------------------------------------
// swkd_pkg
// shared constants, register indexes and the digit pattern decoder for the
// stopwatch keypad and display scanner
// ----------------------------------------------------------------------------
package swkd_pkg;

    // field widths
    localparam int unsigned LinesW   = 4;
    localparam int unsigned PhaseW   = 4;
    localparam int unsigned DigitW   = 4;
    localparam int unsigned SegW     = 8;
    localparam int unsigned PeriodW  = 16;
    localparam int unsigned TicksW   = 8;
    localparam int unsigned KeyW     = 4;
    localparam int unsigned NumDigits = 4;

    // stream widths, whole bytes
    localparam int unsigned InDataW  = 8;
    localparam int unsigned OutBits  = 2 * LinesW + SegW + 2 + NumDigits * DigitW;
    localparam int unsigned OutDataW = ((OutBits + 7) / 8) * 8;

    // configuration port
    localparam int unsigned CfgIndexW = 3;
    localparam int unsigned CfgDataW  = 16;

    localparam logic [CfgIndexW-1:0] REG_SECOND_PERIOD  = 3'd0;
    localparam logic [CfgIndexW-1:0] REG_DEBOUNCE_TICKS = 3'd1;
    localparam logic [CfgIndexW-1:0] REG_RELEASE_TICKS  = 3'd2;
    localparam logic [CfgIndexW-1:0] REG_START_KEY      = 3'd3;
    localparam logic [CfgIndexW-1:0] REG_STOP_KEY       = 3'd4;
    localparam logic [CfgIndexW-1:0] REG_CLEAR_KEY      = 3'd5;

    // register reset values
    localparam logic [PeriodW-1:0] RST_SECOND_PERIOD  = 16'd997;
    localparam logic [TicksW-1:0]  RST_DEBOUNCE_TICKS = 8'd32;
    localparam logic [TicksW-1:0]  RST_RELEASE_TICKS  = 8'd32;
    localparam logic [KeyW-1:0]    RST_START_KEY      = 4'd10;
    localparam logic [KeyW-1:0]    RST_STOP_KEY       = 4'd11;
    localparam logic [KeyW-1:0]    RST_CLEAR_KEY      = 4'd12;

    localparam logic [DigitW-1:0] DIGIT_MAX = 4'd9;

    typedef logic [DigitW-1:0] digit_t;

    // seven-segment pattern of a decimal digit, blank above nine
    function automatic logic [SegW-1:0] seg_pattern(input logic [DigitW-1:0] d);
        logic [SegW-1:0] p;
        case (d)
            4'd0:    p = 8'hfc;
            4'd1:    p = 8'h60;
            4'd2:    p = 8'hda;
            4'd3:    p = 8'hf2;
            4'd4:    p = 8'h66;
            4'd5:    p = 8'hb6;
            4'd6:    p = 8'hbe;
            4'd7:    p = 8'he0;
            4'd8:    p = 8'hfe;
            4'd9:    p = 8'hf6;
            default: p = '0;
        endcase
        return p;
    endfunction

endpackage

// ----- hdl/stopwatch_keypad_display_scanner_unit.sv -----
// ----------------------------------------------------------------------------
// stopwatch_keypad_display_scanner_unit
// one tick per input transfer: display scan, keypad debounce and release,
// and a four-digit decimal seconds counter driven by start/stop/clear keys
// ----------------------------------------------------------------------------
// output: the result of a tick is registered and presented in the cycle after its transfer
// throughput: one tick per cycle while the sink accepts results; all state is updated in the accepting cycle
// and a single output register holds the result while the sink stalls
// reset: synchronous, active low; clears scan, key and counter state and
// loads the register defaults (period 997, debounce 32, release 32, keys 10/11/12)
module stopwatch_keypad_display_scanner_unit (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // tick channel
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    input  logic [swkd_pkg::InDataW-1:0]           s_tdata,   // [3:0] return_lines
    // result channel
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [3:0] select_lines, [11:4] segments, [12] key_held, [16:13] held_code,
    // [17] counting, [21:18] units, [25:22] tens, [29:26] hundreds,
    // [33:30] thousands, rest zero
    output logic [swkd_pkg::OutDataW-1:0]          m_tdata,
    // configuration writes
    input  logic                                   cfg_we,
    input  logic [swkd_pkg::CfgIndexW-1:0]         cfg_index,
    input  logic [swkd_pkg::CfgDataW-1:0]          cfg_wdata
);
    import swkd_pkg::*;

    // configuration registers
    logic [PeriodW-1:0] second_period_reg;
    logic [TicksW-1:0]  debounce_ticks_reg;
    logic [TicksW-1:0]  release_ticks_reg;
    logic [KeyW-1:0]    start_key_reg;
    logic [KeyW-1:0]    stop_key_reg;
    logic [KeyW-1:0]    clear_key_reg;

    // tick state
    logic [PhaseW-1:0]  phase_reg, phase_next;
    logic               debounce_busy_reg, debounce_busy_next;
    logic [TicksW-1:0]  debounce_left_reg, debounce_left_next;
    logic [TicksW-1:0]  release_left_reg, release_left_next;
    logic               confirmed_reg, confirmed_next;
    logic [PhaseW-1:0]  pressed_code_reg, pressed_code_next;
    logic               running_reg, running_next;
    digit_t             digits_reg [NumDigits];
    digit_t             digits_next [NumDigits];
    logic [PeriodW-1:0] period_left_reg, period_left_next;
    logic               advance_due_reg;
    logic [SegW-1:0]    segment_reg, segment_next;
    logic [LinesW-1:0]  select_reg, select_next;

    // output stage
    logic                m_tvalid_reg;
    logic [OutDataW-1:0] m_tdata_reg, m_tdata_next;

    logic              s_xfer;
    logic [LinesW-1:0] lines;
    logic [1:0]        row;
    logic [1:0]        col;
    logic              pressed;
    logic              due_now;
    logic              new_key;

    // a tick is taken whenever the output register is free or draining
    assign s_tready = !m_tvalid_reg || m_tready;
    assign s_xfer   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    assign lines   = s_tdata[LinesW-1:0];
    assign row     = phase_reg[3:2];
    assign col     = phase_reg[1:0];
    assign pressed = !lines[col];

    // period timer: while running, the counter advances on a tick where the timer expires
    assign due_now = advance_due_reg || (period_left_reg <= PeriodW'(1));

    always_comb begin
        period_left_next = due_now ? second_period_reg : period_left_reg - PeriodW'(1);
    end

    // display scan: first phase of a group selects the digit and latches its
    // pattern, fourth phase blanks the segments
    always_comb begin
        select_next  = select_reg;
        segment_next = segment_reg;
        if (col == 2'd0) begin
            select_next  = ~(LinesW'(1) << row);
            segment_next = seg_pattern(digits_reg[row]);
        end else if (col == 2'd3) begin
            segment_next = '0;
        end
    end

    // key machine: press, debounce recheck, hold until a run of releases
    always_comb begin
        debounce_busy_next = debounce_busy_reg;
        debounce_left_next = debounce_left_reg;
        release_left_next  = release_left_reg;
        confirmed_next     = confirmed_reg;
        pressed_code_next  = pressed_code_reg;
        new_key            = 1'b0;
        if (confirmed_reg) begin
            if (pressed) begin
                release_left_next = release_ticks_reg;
            end else if (release_left_reg <= TicksW'(1)) begin
                confirmed_next    = 1'b0;
                release_left_next = release_ticks_reg;
            end else begin
                release_left_next = release_left_reg - TicksW'(1);
            end
        end else if (!debounce_busy_reg) begin
            if (pressed) begin
                debounce_busy_next = 1'b1;
                debounce_left_next = debounce_ticks_reg;
                pressed_code_next  = phase_reg;
            end
        end else if (debounce_left_reg <= TicksW'(1)) begin
            debounce_busy_next = 1'b0;
            debounce_left_next = '0;
            if (pressed) begin
                confirmed_next = 1'b1;
                new_key        = 1'b1;
            end
        end else begin
            debounce_left_next = debounce_left_reg - TicksW'(1);
        end
    end

    assign phase_next = phase_reg + PhaseW'(1);

    // decimal counter with ripple carry across the four digits, then the key
    // action; clear beats stop, stop beats start
    always_comb begin
        logic carry;
        carry        = due_now && running_reg;
        running_next = running_reg;
        for (int i = 0; i < NumDigits; i++) begin
            digits_next[i] = digits_reg[i];
            if (carry) begin
                if (digits_reg[i] >= DIGIT_MAX) begin
                    digits_next[i] = '0;
                end else begin
                    digits_next[i] = digits_reg[i] + DigitW'(1);
                    carry          = 1'b0;
                end
            end
        end
        if (new_key) begin
            if (pressed_code_reg == clear_key_reg) begin
                running_next = 1'b0;
                for (int i = 0; i < NumDigits; i++) begin
                    digits_next[i] = '0;
                end
            end else if (pressed_code_reg == stop_key_reg) begin
                running_next = 1'b0;
            end else if (pressed_code_reg == start_key_reg) begin
                running_next = 1'b1;
            end
        end
    end

    // result packing, select lines in the lowest bits
    always_comb begin
        m_tdata_next = OutDataW'({digits_next[3], digits_next[2], digits_next[1],
                                  digits_next[0], running_next, pressed_code_next,
                                  confirmed_next, segment_next, select_next});
    end

    // configuration writes; unknown indexes are ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            second_period_reg  <= RST_SECOND_PERIOD;
            debounce_ticks_reg <= RST_DEBOUNCE_TICKS;
            release_ticks_reg  <= RST_RELEASE_TICKS;
            start_key_reg      <= RST_START_KEY;
            stop_key_reg       <= RST_STOP_KEY;
            clear_key_reg      <= RST_CLEAR_KEY;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_SECOND_PERIOD:  second_period_reg  <= cfg_wdata[PeriodW-1:0];
                REG_DEBOUNCE_TICKS: debounce_ticks_reg <= cfg_wdata[TicksW-1:0];
                REG_RELEASE_TICKS:  release_ticks_reg  <= cfg_wdata[TicksW-1:0];
                REG_START_KEY:      start_key_reg      <= cfg_wdata[KeyW-1:0];
                REG_STOP_KEY:       stop_key_reg       <= cfg_wdata[KeyW-1:0];
                REG_CLEAR_KEY:      clear_key_reg      <= cfg_wdata[KeyW-1:0];
                default: ;
            endcase
        end
    end

    // tick state, updated on every tick transfer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= '0;
            debounce_busy_reg <= 1'b0;
            debounce_left_reg <= '0;
            release_left_reg  <= RST_RELEASE_TICKS;
            confirmed_reg     <= 1'b0;
            pressed_code_reg  <= '0;
            running_reg       <= 1'b0;
            period_left_reg   <= '0;
            advance_due_reg   <= 1'b1;
            segment_reg       <= '0;
            select_reg        <= '1;
            for (int i = 0; i < NumDigits; i++) begin
                digits_reg[i] <= '0;
            end
        end else if (s_xfer) begin
            phase_reg         <= phase_next;
            debounce_busy_reg <= debounce_busy_next;
            debounce_left_reg <= debounce_left_next;
            release_left_reg  <= release_left_next;
            confirmed_reg     <= confirmed_next;
            pressed_code_reg  <= pressed_code_next;
            running_reg       <= running_next;
            period_left_reg   <= period_left_next;
            advance_due_reg   <= 1'b0;
            segment_reg       <= segment_next;
            select_reg        <= select_next;
            for (int i = 0; i < NumDigits; i++) begin
                digits_reg[i] <= digits_next[i];
            end
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s_xfer) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_xfer) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

    // at most one digit selected at any time
    a_select_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        $onehot0(~select_reg))
        else $error("more than one digit selected");

    // a held key never coexists with a running debounce
    a_held_not_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        confirmed_reg |-> !debounce_busy_reg)
        else $error("debounce active while key held");

    // the blanking phase always yields dark segments
    a_blank_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_xfer && col == 2'd3) |=> (m_tdata_reg[2*LinesW-1+SegW-LinesW:LinesW] == '0))
        else $error("segments not blanked on fourth phase");

    // counter digits stay decimal
    a_digits_decimal: assert property (@(posedge aclk) disable iff (!aresetn)
        digits_reg[0] <= DIGIT_MAX && digits_reg[1] <= DIGIT_MAX &&
        digits_reg[2] <= DIGIT_MAX && digits_reg[3] <= DIGIT_MAX)
        else $error("counter digit above nine");

endmodule
